### rtl/ema_loop_count_calibrator_macros.svh
// Assertion macros for the loop count calibrator.
`ifndef EMA_LOOP_COUNT_CALIBRATOR_MACROS_SVH
`define EMA_LOOP_COUNT_CALIBRATOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define EMALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define EMALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EMALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define EMALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/emalc_pkg.sv
// Shared types and constants of the loop count calibrator.
package emalc_pkg;

  localparam int unsigned CALLS_W    = 20;
  localparam int unsigned ELAPSED_W  = 32;
  localparam int unsigned COUNT_W    = 31;
  localparam int unsigned TARGET_W   = 20;
  localparam int unsigned Q16_W      = 16;
  localparam int unsigned AVG_OUT_W  = 36;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // datapath word and shared adder width
  localparam int unsigned WORD_W = 64;
  localparam int unsigned ALU_W  = WORD_W + 1;
  localparam int unsigned PROD_W = 2 * WORD_W;

  // product alignment in the 128-bit shift register after serial multiply
  localparam int unsigned P16_LSB = WORD_W - Q16_W;
  localparam int unsigned PC_LSB  = WORD_W - COUNT_W;

  localparam logic [WORD_W-1:0] AVG_OUT_MAX = (64'd1 << AVG_OUT_W) - 64'd1;
  localparam logic [WORD_W-1:0] RND_HALF_UP = 64'd32768;
  localparam logic [WORD_W-1:0] RND_HALF_DN = 64'd32767;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DBAND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH  = 3'd5;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST = 20'd1000;
  localparam logic [COUNT_W-1:0]  MAX_RST    = 31'h7FFF_FFFF;
  localparam logic [COUNT_W-1:0]  INIT_RST   = 31'd1000;
  localparam logic [Q16_W-1:0]    GAIN_RST   = 16'd13107;
  localparam logic [Q16_W-1:0]    DBAND_RST  = 16'd3277;
  localparam logic [Q16_W-1:0]    SMOOTH_RST = 16'd32768;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_SDIV,
    S_EMA_SUB,
    S_EMA_NEG,
    S_EMA_MUL,
    S_EMA_RND,
    S_EMA_APPLY,
    S_DB_SUB,
    S_DB_NEG,
    S_DB_BIG,
    S_DB_MUL,
    S_DB_CMP,
    S_W_MUL,
    S_W_SUM,
    S_C_MUL,
    S_H_LO,
    S_H_HI,
    S_BIG,
    S_CDIV,
    S_CLAMP,
    S_OUT
  } state_e;

endpackage

### rtl/emalc_in_if.sv
// Measurement request channel.
interface emalc_in_if
  import emalc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CALLS_W-1:0]   call_count;
  logic [ELAPSED_W-1:0] elapsed_us;

  modport source (output valid, call_count, elapsed_us, input ready);
  modport sink   (input valid, call_count, elapsed_us, output ready);
endinterface

### rtl/emalc_out_if.sv
// Result request channel.
interface emalc_out_if
  import emalc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [COUNT_W-1:0]   loop_count;
  logic                 changed;
  logic [AVG_OUT_W-1:0] average_us_q16;
  logic                 ignored;

  modport source (output valid, loop_count, changed, average_us_q16, ignored, input ready);
  modport sink   (input valid, loop_count, changed, average_us_q16, ignored, output ready);
endinterface

### rtl/emalc_addsub.sv
// Shared 65-bit adder/subtractor with carry/borrow out.
module emalc_addsub
  import emalc_pkg::*;
(
  input  alu_req_t     req_i,
  output logic [ALU_W:0] res_o
);
  assign res_o = req_i.sub ? ({1'b0, req_i.a} - {1'b0, req_i.b})
                           : ({1'b0, req_i.a} + {1'b0, req_i.b});
endmodule

### rtl/ema_loop_count_calibrator.sv
// Loop count calibrator: moving-average per-call time and deadband count correction.
//
// Each measurement request (call count, busy time in us) yields one result
// request. A request with a zero count or zero time is flagged as ignored and
// returned with the state untouched. Otherwise the block works the request
// through one shared 65-bit adder/subtractor under a sequencer: restoring
// division for the per-call sample (33+FRAC_BITS steps), serial 16-bit
// multiplies for the average gain, the deadband test and the smoothing weight,
// a 31-step multiply by the loop count and a 64-step restoring divide for the
// new count. The serial steps take one bit per cycle through that adder; a
// request whose average sits inside the deadband skips the weight multiply,
// the count multiply and the divide. The measurement side is ready only while
// the sequencer is idle; a finished result sits in an output register, so the
// next measurement is taken while that result still waits. Configuration is
// a plain write port (index, data); writing initial_loop_count reloads the
// loop count at once, writing the target leaves the average as it is.
`include "ema_loop_count_calibrator_macros.svh"

module ema_loop_count_calibrator
  import emalc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  emalc_in_if.sink              meas_i,
  emalc_out_if.source           res_o
);

  // average is Q24.FRAC_BITS, target Q20.FRAC_BITS
  localparam int unsigned AW = 24 + FRAC_BITS;
  localparam int unsigned TW = TARGET_W + FRAC_BITS;
  // sample dividend: (elapsed << FRAC_BITS) + calls/2, one bit of headroom
  localparam int unsigned NW = ELAPSED_W + FRAC_BITS + 1;

  localparam logic [6:0] SDIV_STEPS = 7'(NW);
  localparam logic [6:0] Q16_STEPS  = 7'(Q16_W);
  localparam logic [6:0] CNT_STEPS  = 7'(COUNT_W);
  localparam logic [6:0] CDIV_STEPS = 7'(WORD_W);

  localparam logic [AW-1:0] AVG_RST = AW'(TARGET_RST) << FRAC_BITS;

  // configuration registers
  logic [TARGET_W-1:0] tgt_q;
  logic [COUNT_W-1:0]  max_q;
  logic [Q16_W-1:0]    gain_q;
  logic [Q16_W-1:0]    dband_q;
  logic [Q16_W-1:0]    smooth_q;

  // sequencer and datapath
  state_e               state_q, state_d;
  logic [PROD_W-1:0]    p_q, p_d;        // remainder:quotient or product shift register
  logic [WORD_W-1:0]    mc_q, mc_d;      // multiplicand or divisor
  logic [6:0]           cnt_q, cnt_d;
  logic [AW-1:0]        avg_q, avg_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [WORD_W-1:0]    dabs_q, dabs_d;  // |avg - T|, or the EMA step
  logic                 lt_q, lt_d;      // sign flag, later the rounding carry
  logic [CALLS_W-1:0]   calls_q, calls_d;
  logic [ELAPSED_W-1:0] elap_q, elap_d;
  logic                 chg_q, chg_d;
  logic                 ign_q, ign_d;

  // output register
  logic                 ov_q, ov_d;
  logic [COUNT_W-1:0]   ocnt_q, ocnt_d;
  logic                 ochg_q, ochg_d;
  logic [AVG_OUT_W-1:0] oavg_q, oavg_d;
  logic                 oign_q, oign_d;

  alu_req_t          alu_req, mul_req, div_req;
  logic [ALU_W:0]    alu_res;
  logic              borrow;

  logic [TARGET_W-1:0] tgt_eff;
  logic [COUNT_W-1:0]  mx_eff;
  logic [TW-1:0]       t_val;
  logic [WORD_W-1:0]   t64, avg64, q_lo, prod16, adj_d;
  logic [AW-1:0]       sample_w;
  logic [AVG_OUT_W-1:0] avg_out;
  logic [PROD_W-1:0]   p_mul, p_div;
  logic [WORD_W-1:0]   div_rr;
  logic                div_ge;
  logic [COUNT_W-1:0]  new_cnt;
  logic                in_acc, in_skip;

  emalc_addsub u_addsub (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  // zero target / zero max behave as one
  assign tgt_eff = (tgt_q == '0) ? TARGET_W'(1) : tgt_q;
  assign mx_eff  = (max_q == '0) ? COUNT_W'(1) : max_q;
  assign t_val   = {tgt_eff, {FRAC_BITS{1'b0}}};
  assign t64     = WORD_W'(t_val);
  assign avg64   = WORD_W'(avg_q);
  assign q_lo    = p_q[WORD_W-1:0];
  assign prod16  = p_q[P16_LSB +: WORD_W];
  assign adj_d   = avg64 << Q16_W;
  assign borrow  = alu_res[ALU_W];

  // per-call sample saturates to the top of the average range
  assign sample_w = ((q_lo >> AW) != '0) ? {AW{1'b1}} : q_lo[AW-1:0];
  assign avg_out  = (avg64 > AVG_OUT_MAX) ? '1 : avg64[AVG_OUT_W-1:0];

  // serial multiply step: add multiplicand on LSB, shift right
  assign mul_req = '{a: {1'b0, p_q[PROD_W-1:WORD_W]}, b: {1'b0, mc_q}, sub: 1'b0};
  assign p_mul   = p_q[0] ? {alu_res[ALU_W-1:0], p_q[WORD_W-1:1]}
                          : {1'b0, p_q[PROD_W-1:1]};

  // restoring divide step: remainder in the top half, dividend/quotient below
  assign div_rr  = {p_q[PROD_W-2:WORD_W], p_q[WORD_W-1]};
  assign div_req = '{a: {p_q[PROD_W-1], div_rr}, b: {1'b0, mc_q}, sub: 1'b1};
  assign div_ge  = ~alu_res[ALU_W];
  assign p_div   = {div_ge ? alu_res[WORD_W-1:0] : div_rr, p_q[WORD_W-2:0], div_ge};

  assign meas_i.ready = (state_q == S_IDLE);
  assign in_acc  = meas_i.valid & meas_i.ready;
  assign in_skip = (meas_i.call_count == '0) | (meas_i.elapsed_us == '0);

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    mc_d    = mc_q;
    cnt_d   = cnt_q;
    avg_d   = avg_q;
    count_d = count_q;
    dabs_d  = dabs_q;
    lt_d    = lt_q;
    calls_d = calls_q;
    elap_d  = elap_q;
    chg_d   = chg_q;
    ign_d   = ign_q;
    ov_d    = ov_q & ~res_o.ready;
    ocnt_d  = ocnt_q;
    ochg_d  = ochg_q;
    oavg_d  = oavg_q;
    oign_d  = oign_q;
    alu_req = '{a: '0, b: '0, sub: 1'b0};
    new_cnt = count_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          calls_d = meas_i.call_count;
          elap_d  = meas_i.elapsed_us;
          chg_d   = 1'b0;
          ign_d   = in_skip;
          state_d = in_skip ? S_OUT : S_PREP;
        end
      end
      S_PREP: begin
        // dividend with half the divisor added for round half up
        alu_req = '{a: ALU_W'({elap_q, {FRAC_BITS{1'b0}}}),
                    b: ALU_W'(calls_q >> 1), sub: 1'b0};
        p_d     = {{WORD_W{1'b0}}, alu_res[WORD_W-1:0] << (WORD_W - NW)};
        mc_d    = WORD_W'(calls_q);
        cnt_d   = SDIV_STEPS;
        state_d = S_SDIV;
      end
      S_SDIV: begin
        alu_req = div_req;
        p_d     = p_div;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_EMA_SUB;
        end
      end
      S_EMA_SUB: begin
        alu_req = '{a: ALU_W'(sample_w), b: ALU_W'(avg_q), sub: 1'b1};
        if (!borrow) begin
          mc_d    = alu_res[WORD_W-1:0];
          lt_d    = 1'b0;
          p_d     = PROD_W'(gain_q);
          cnt_d   = Q16_STEPS;
          state_d = S_EMA_MUL;
        end else begin
          state_d = S_EMA_NEG;
        end
      end
      S_EMA_NEG: begin
        alu_req = '{a: ALU_W'(avg_q), b: ALU_W'(sample_w), sub: 1'b1};
        mc_d    = alu_res[WORD_W-1:0];
        lt_d    = 1'b1;
        p_d     = PROD_W'(gain_q);
        cnt_d   = Q16_STEPS;
        state_d = S_EMA_MUL;
      end
      S_EMA_MUL: begin
        alu_req = mul_req;
        p_d     = p_mul;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_EMA_RND;
        end
      end
      S_EMA_RND: begin
        // rising: round half up; falling: half rounds toward the old average
        alu_req = '{a: ALU_W'(prod16), b: ALU_W'(lt_q ? RND_HALF_DN : RND_HALF_UP),
                    sub: 1'b0};
        dabs_d  = WORD_W'(alu_res[ALU_W-1:Q16_W]);
        state_d = S_EMA_APPLY;
      end
      S_EMA_APPLY: begin
        alu_req = '{a: ALU_W'(avg_q), b: ALU_W'(dabs_q), sub: lt_q};
        avg_d   = alu_res[AW-1:0];
        state_d = S_DB_SUB;
      end
      S_DB_SUB: begin
        alu_req = '{a: ALU_W'(avg_q), b: ALU_W'(t_val), sub: 1'b1};
        if (!borrow) begin
          dabs_d  = alu_res[WORD_W-1:0];
          lt_d    = 1'b0;
          state_d = S_DB_BIG;
        end else begin
          state_d = S_DB_NEG;
        end
      end
      S_DB_NEG: begin
        alu_req = '{a: ALU_W'(t_val), b: ALU_W'(avg_q), sub: 1'b1};
        dabs_d  = alu_res[WORD_W-1:0];
        lt_d    = 1'b1;
        state_d = S_DB_BIG;
      end
      S_DB_BIG: begin
        // drift of a whole target or more adjusts, unless the average is zero
        alu_req = '{a: ALU_W'(dabs_q), b: ALU_W'(t64), sub: 1'b1};
        if (!borrow) begin
          p_d     = PROD_W'(smooth_q);
          mc_d    = dabs_q;
          cnt_d   = Q16_STEPS;
          state_d = (avg_q == '0) ? S_OUT : S_W_MUL;
        end else begin
          p_d     = PROD_W'(dband_q);
          mc_d    = t64;
          cnt_d   = Q16_STEPS;
          state_d = S_DB_MUL;
        end
      end
      S_DB_MUL: begin
        alu_req = mul_req;
        p_d     = p_mul;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_DB_CMP;
        end
      end
      S_DB_CMP: begin
        alu_req = '{a: ALU_W'(dabs_q << Q16_W), b: ALU_W'(prod16), sub: 1'b1};
        if (!borrow) begin
          p_d     = PROD_W'(smooth_q);
          mc_d    = dabs_q;
          cnt_d   = Q16_STEPS;
          state_d = (avg_q == '0) ? S_OUT : S_W_MUL;
        end else begin
          state_d = S_OUT;
        end
      end
      S_W_MUL: begin
        alu_req = mul_req;
        p_d     = p_mul;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_W_SUM;
        end
      end
      S_W_SUM: begin
        // w = (avg << 16) + s*(T - avg), modulo 2^64
        alu_req = '{a: ALU_W'(adj_d), b: ALU_W'(prod16), sub: ~lt_q};
        mc_d    = alu_res[WORD_W-1:0];
        p_d     = PROD_W'(count_q);
        cnt_d   = CNT_STEPS;
        state_d = S_C_MUL;
      end
      S_C_MUL: begin
        alu_req = mul_req;
        p_d     = p_mul;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_H_LO;
        end
      end
      S_H_LO: begin
        // add avg << 15 for rounding; realign count*w to hi:lo
        alu_req = '{a: ALU_W'(p_q[PC_LSB +: WORD_W]), b: ALU_W'(avg64 << (Q16_W - 1)),
                    sub: 1'b0};
        p_d     = {WORD_W'(p_q[PC_LSB + WORD_W +: COUNT_W]), alu_res[WORD_W-1:0]};
        lt_d    = alu_res[WORD_W];
        state_d = S_H_HI;
      end
      S_H_HI: begin
        alu_req = '{a: ALU_W'(p_q[PROD_W-1:WORD_W]), b: ALU_W'(lt_q), sub: 1'b0};
        p_d     = {alu_res[WORD_W-1:0], q_lo};
        state_d = S_BIG;
      end
      S_BIG: begin
        // quotient would not fit 64 bits: clamp to max
        alu_req = '{a: ALU_W'(p_q[PROD_W-1:WORD_W]), b: ALU_W'(adj_d), sub: 1'b1};
        mc_d    = adj_d;
        cnt_d   = CDIV_STEPS;
        if (!borrow) begin
          new_cnt = mx_eff;
          if (new_cnt != count_q) begin
            count_d = new_cnt;
            chg_d   = 1'b1;
          end
          state_d = S_OUT;
        end else begin
          state_d = S_CDIV;
        end
      end
      S_CDIV: begin
        alu_req = div_req;
        p_d     = p_div;
        cnt_d   = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_CLAMP;
        end
      end
      S_CLAMP: begin
        alu_req = '{a: ALU_W'(mx_eff), b: ALU_W'(q_lo), sub: 1'b1};
        if (borrow) begin
          new_cnt = mx_eff;
        end else if (q_lo == '0) begin
          new_cnt = COUNT_W'(1);
        end else begin
          new_cnt = q_lo[COUNT_W-1:0];
        end
        if (new_cnt != count_q) begin
          count_d = new_cnt;
          chg_d   = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          ocnt_d  = count_q;
          ochg_d  = chg_q;
          oavg_d  = avg_out;
          oign_d  = ign_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // writing the initial count reloads the live count
    if (cfg_we_i && (cfg_idx_i == CFG_INITIAL)) begin
      count_d = (cfg_wdata_i == '0) ? COUNT_W'(1) : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q    <= TARGET_RST;
      max_q    <= MAX_RST;
      gain_q   <= GAIN_RST;
      dband_q  <= DBAND_RST;
      smooth_q <= SMOOTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET:  tgt_q    <= cfg_wdata_i[TARGET_W-1:0];
        CFG_MAX:     max_q    <= cfg_wdata_i;
        CFG_GAIN:    gain_q   <= cfg_wdata_i[Q16_W-1:0];
        CFG_DBAND:   dband_q  <= cfg_wdata_i[Q16_W-1:0];
        CFG_SMOOTH:  smooth_q <= cfg_wdata_i[Q16_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      avg_q   <= AVG_RST;
      count_q <= INIT_RST;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      avg_q   <= avg_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    mc_q    <= mc_d;
    cnt_q   <= cnt_d;
    dabs_q  <= dabs_d;
    lt_q    <= lt_d;
    calls_q <= calls_d;
    elap_q  <= elap_d;
    chg_q   <= chg_d;
    ign_q   <= ign_d;
    ocnt_q  <= ocnt_d;
    ochg_q  <= ochg_d;
    oavg_q  <= oavg_d;
    oign_q  <= oign_d;
  end

  assign res_o.valid          = ov_q;
  assign res_o.loop_count     = ocnt_q;
  assign res_o.changed        = ochg_q;
  assign res_o.average_us_q16 = oavg_q;
  assign res_o.ignored        = oign_q;

  `EMALC_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, 1'b1, count_q != '0, "loop count is zero")
  `EMALC_ASSERT_IMP(a_ignored_no_change, clk_i, rst_ni, res_o.valid && res_o.ignored, !res_o.changed, "ignored result flagged as changed")
  `EMALC_ASSERT_NXT(a_skip_keeps_avg, clk_i, rst_ni, in_acc && in_skip, $stable(avg_q), "ignored measurement moved the average")

endmodule

### verif/ema_loop_count_calibrator_tb.sv
// Self-checking testbench for the loop count calibrator: random handshakes, own predictor.
`timescale 1ns / 100ps

module ema_loop_count_calibrator_tb;
  import emalc_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 250;

  // largest Q24.16 average the block can hold
  localparam logic [63:0] AVG_CEIL = (64'd1 << (24 + FRAC)) - 64'd1;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CFG_DATA_W-1:0] COUNT_TOP  = 31'h7FFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] TARGET_TOP = 31'd1000000;
  localparam logic [CFG_DATA_W-1:0] Q16_TOP    = 31'd65535;
  localparam logic [ELAPSED_W-1:0]  BUSY_TOP   = 32'hFFFF_FFFF;
  localparam logic [CALLS_W-1:0]    CALLS_TOP  = 20'hF_FFFF;

  typedef struct packed {
    logic [CALLS_W-1:0]   calls;
    logic [ELAPSED_W-1:0] elapsed;
  } meas_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   loop_count;
    logic                 changed;
    logic [AVG_OUT_W-1:0] average;
    logic                 ignored;
  } calib_t;

  // every input starts at a known level
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic [CALLS_W-1:0]    in_calls   = '0;
  logic [ELAPSED_W-1:0]  in_elapsed = '0;
  logic                  out_ready  = 1'b0;

  emalc_in_if  meas_if ();
  emalc_out_if res_if ();

  assign meas_if.valid      = in_valid;
  assign meas_if.call_count = in_calls;
  assign meas_if.elapsed_us = in_elapsed;
  assign res_if.ready       = out_ready;

  ema_loop_count_calibrator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .meas_i      (meas_if),
    .res_o       (res_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: register shadow and calibration state
  // ---------------------------------------------------------------------------
  logic [TARGET_W-1:0] m_target;
  logic [COUNT_W-1:0]  m_max;
  logic [COUNT_W-1:0]  m_initial;
  logic [Q16_W-1:0]    m_gain;
  logic [Q16_W-1:0]    m_dband;
  logic [Q16_W-1:0]    m_smooth;
  logic [63:0]         m_avg;     // Q24.16 moving average
  logic [COUNT_W-1:0]  m_count;

  meas_t       pending_meas [$];  // requests not yet offered to the block
  calib_t      awaited [$];       // results owed by the block, oldest first
  int unsigned mismatches = 0;

  // a zero target counts as one microsecond
  function automatic logic [TARGET_W-1:0] eff_target();
    return (m_target == '0) ? TARGET_W'(1) : m_target;
  endfunction

  function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TARGET:  m_target = data[TARGET_W-1:0];
      CFG_MAX:     m_max    = data[COUNT_W-1:0];
      CFG_INITIAL: begin
        // loop count follows the initial value straight away, never below one
        m_initial = data[COUNT_W-1:0];
        m_count   = (m_initial == '0) ? COUNT_W'(1) : m_initial;
      end
      CFG_GAIN:    m_gain   = data[Q16_W-1:0];
      CFG_DBAND:   m_dband  = data[Q16_W-1:0];
      CFG_SMOOTH:  m_smooth = data[Q16_W-1:0];
      default: ;
    endcase
  endfunction

  // Folds one measurement into the average and works out the loop count.
  function automatic calib_t calibrate(input logic [CALLS_W-1:0]   calls,
                                       input logic [ELAPSED_W-1:0] elapsed);
    logic [63:0]  sample;
    logic [63:0]  tq;
    logic [63:0]  dev;
    logic [63:0]  w;
    logic [127:0] num;
    logic [127:0] quot;
    logic [127:0] cap;
    logic         adjust;
    calib_t       r;
    r.changed = 1'b0;
    r.ignored = 1'b0;
    if (calls == '0 || elapsed == '0) begin
      r.ignored = 1'b1;
    end else begin
      // per-call time, rounded half up, saturated to the average's range
      sample = ((64'(elapsed) << FRAC) + 64'(calls >> 1)) / 64'(calls);
      if (sample > AVG_CEIL) sample = AVG_CEIL;
      // moving average step; rounding is half up in both directions
      if (sample >= m_avg) begin
        m_avg = m_avg + ((64'(m_gain) * (sample - m_avg) + RND_HALF_UP) >> 16);
      end else begin
        m_avg = m_avg - ((64'(m_gain) * (m_avg - sample) + RND_HALF_DN) >> 16);
      end
      tq  = 64'(eff_target()) << FRAC;
      dev = (m_avg >= tq) ? m_avg - tq : tq - m_avg;
      // drift of 100% or more always adjusts, else compare against the deadband
      adjust = (dev >= tq) || ((dev << 16) >= 64'(m_dband) * tq);
      if (adjust && m_avg != 64'd0) begin
        // count * ((1-s)*avg + s*T) / avg, s in Q0.16, rounded half up
        w    = (64'd65536 - 64'(m_smooth)) * m_avg + 64'(m_smooth) * tq;
        num  = 128'(m_count) * 128'(w) + (128'(m_avg) << 15);
        quot = num / (128'(m_avg) << 16);
        cap  = (m_max == '0) ? 128'd1 : 128'(m_max);
        if (quot > cap) quot = cap;
        if (quot == 128'd0) quot = 128'd1;
        if (quot[COUNT_W-1:0] != m_count) begin
          m_count   = quot[COUNT_W-1:0];
          r.changed = 1'b1;
        end
      end
    end
    r.loop_count = m_count;
    r.average    = (m_avg > AVG_OUT_MAX) ? AVG_OUT_MAX[AVG_OUT_W-1:0]
                                         : m_avg[AVG_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers queued measurements, random gaps between requests
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;  // stretch with no gaps
  meas_t       next_meas;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid && meas_if.ready) begin
        // request taken: predict its result now, under the current registers
        awaited.push_back(calibrate(in_calls, in_elapsed));
        send_gap = send_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end
      // a request on offer but not yet taken is held as it is
      if (!(in_valid && !meas_if.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_meas.size() != 0) begin
          next_meas   = pending_meas.pop_front();
          in_valid   <= 1'b1;
          in_calls   <= next_meas.calls;
          in_elapsed <= next_meas.elapsed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field check
  // ---------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  bit          recv_calm  = 1'b0;
  calib_t      want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (res_if.valid && out_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("unrequested result, loop_count", 64'(res_if.loop_count), 64'd0);
        end else begin
          want = awaited.pop_front();
          if (res_if.loop_count !== want.loop_count)
            report_mismatch("loop_count", 64'(res_if.loop_count), 64'(want.loop_count));
          if (res_if.changed !== want.changed)
            report_mismatch("changed", 64'(res_if.changed), 64'(want.changed));
          if (res_if.average_us_q16 !== want.average)
            report_mismatch("average_us_q16", 64'(res_if.average_us_q16),
                            64'(want.average));
          if (res_if.ignored !== want.ignored)
            report_mismatch("ignored", 64'(res_if.ignored), 64'(want.ignored));
        end
        recv_stall = recv_calm ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    load_register(idx, data);
  endtask

  function automatic void queue_meas(input logic [CALLS_W-1:0]   calls,
                                     input logic [ELAPSED_W-1:0] elapsed);
    meas_t m;
    m.calls   = calls;
    m.elapsed = elapsed;
    pending_meas.push_back(m);
  endfunction

  // Waits until every queued request has been taken and answered.
  task automatic wait_quiet();
    while (pending_meas.size() != 0 || in_valid || awaited.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Extremes now and then, otherwise a value from the usual span.
  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_DATA_W-1:0] lo,
                                                       input logic [CFG_DATA_W-1:0] hi,
                                                       input int unsigned typ_lo,
                                                       input int unsigned typ_hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return CFG_DATA_W'($urandom_range(typ_lo, typ_hi));
  endfunction

  // Mostly busy times close to the target per call so the deadband is hit
  // from both sides; some noise and some requests that should be ignored.
  function automatic meas_t random_meas();
    meas_t       m;
    logic [63:0] busy;
    int unsigned kind;
    int unsigned pct;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      m.calls   = '0;
      m.elapsed = $urandom;
    end else if (kind < 8) begin
      m.calls   = CALLS_W'($urandom);
      m.elapsed = '0;
    end else if (kind < 20) begin
      m.calls   = CALLS_W'($urandom);
      m.elapsed = $urandom;
    end else begin
      m.calls = ($urandom_range(0, 9) == 0) ? CALLS_W'($urandom_range(1, 1048575))
                                            : CALLS_W'($urandom_range(1, 64));
      pct  = ($urandom_range(0, 2) == 0) ? $urandom_range(94, 106) : $urandom_range(40, 180);
      busy = 64'(m.calls) * 64'(eff_target()) * 64'(pct) / 64'd100;
      if (busy == 64'd0) busy = 64'd1;
      m.elapsed = (busy > 64'(BUSY_TOP)) ? BUSY_TOP : busy[ELAPSED_W-1:0];
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned k;
    m_target  = TARGET_RST;
    m_max     = MAX_RST;
    m_initial = INIT_RST;
    m_gain    = GAIN_RST;
    m_dband   = DBAND_RST;
    m_smooth  = SMOOTH_RST;
    m_avg     = 64'(TARGET_RST) << FRAC;
    m_count   = INIT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: ignored requests, on-target, off-target, field extremes
    queue_meas('0, 32'd5);
    queue_meas(20'd5, '0);
    queue_meas('0, '0);
    queue_meas(20'd1, 32'd1000);
    queue_meas(20'd10, 32'd20000);
    queue_meas(CALLS_TOP, BUSY_TOP);
    queue_meas(20'd1, BUSY_TOP);     // per-call time saturates
    wait_quiet();

    // full gain and smoothing, big target: average collapses towards one,
    // the correction overflows and clamps, then the average reaches zero
    write_reg(CFG_TARGET, TARGET_TOP);
    write_reg(CFG_GAIN, Q16_TOP);
    write_reg(CFG_SMOOTH, Q16_TOP);
    write_reg(CFG_DBAND, '0);
    write_reg(CFG_MAX, COUNT_TOP);
    write_reg(CFG_INITIAL, COUNT_TOP);
    repeat (4) queue_meas(20'd65536, 32'd1);
    repeat (3) queue_meas(CALLS_TOP, 32'd1);
    wait_quiet();

    // zero target, zero max and zero initial; writes past the list dropped
    write_reg(CFG_TARGET, '0);
    write_reg(CFG_MAX, '0);
    write_reg(CFG_INITIAL, '0);
    write_reg(CFG_GAIN, '0);
    write_reg(CFG_DBAND, Q16_TOP);
    write_reg(CFG_SMOOTH, '0);
    write_reg(CFG_SPARE_LO, COUNT_TOP);
    write_reg(CFG_SPARE_HI, 31'h2AAA_AAAA);
    queue_meas(20'd3, 32'd7);
    queue_meas(20'd1, 32'd2);
    wait_quiet();

    // target data above its field width, average driven past the output range
    write_reg(CFG_TARGET, 31'h7FF0_0400);
    write_reg(CFG_GAIN, Q16_TOP);
    write_reg(CFG_SMOOTH, 31'd32768);
    write_reg(CFG_MAX, 31'd1000);
    write_reg(CFG_INITIAL, 31'd500);
    repeat (2) queue_meas(20'd1, BUSY_TOP);
    wait_quiet();

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_TARGET, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                        : pick_value(1, TARGET_TOP, 1, 5000));
      write_reg(CFG_MAX, pick_value(1, COUNT_TOP, 1, 100000));
      write_reg(CFG_GAIN, pick_value('0, Q16_TOP, 0, 65535));
      write_reg(CFG_DBAND, pick_value('0, Q16_TOP, 0, 8000));
      write_reg(CFG_SMOOTH, pick_value('0, Q16_TOP, 0, 65535));
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DATA_W'($urandom));
      write_reg(CFG_INITIAL, pick_value('0, COUNT_TOP, 1, 20000));
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pending_meas.push_back(random_meas());
        // sender holds off mid-phase until everything is answered
        if (k == PHASE_ITEMS / 2) wait_quiet();
      end
      wait_quiet();
    end

    // let any stray result show up before judging
    repeat (250) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ema_loop_count_calibrator test passed");
    end else begin
      $display("ema_loop_count_calibrator test failed");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run
  initial begin
    #20_000_000;
    $display("ema_loop_count_calibrator test failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/emalc_pkg.sv
rtl/emalc_in_if.sv
rtl/emalc_out_if.sv
rtl/emalc_addsub.sv
rtl/ema_loop_count_calibrator.sv
verif/ema_loop_count_calibrator_tb.sv
